// ===== hw/rtl/tile_map_box_collision_slide_defines.svh =====
// ----------------------------------------------------------------------------
// tile map box collision: assertion macros
// shared assertion wrappers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_BOX_COLLISION_SLIDE_DEFINES_SVH
`define TILE_MAP_BOX_COLLISION_SLIDE_DEFINES_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle as the antecedent
`define TMBC_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tmbc assertion failed");

// consequent must hold in the cycle after the antecedent
`define TMBC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tmbc assertion failed");

`else

`define TMBC_ASSERT_SAME(name, clk, rst, ante, cons)
`define TMBC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/tmbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmbc_pkg
// shared types, codes and saturation helper for the box collision mover
// ----------------------------------------------------------------------------
package tmbc_pkg;

  localparam int COORD_W  = 21;
  localparam int EXT_W    = 20;
  localparam int SPEED_W  = 24;
  localparam int DIR_W    = 16;
  localparam int TIME_W   = 16;
  localparam int CALC_W   = 24;
  localparam int SNAP_EPS = 3;
  localparam int WALL_T   = 1024;

  // request kinds
  localparam logic [2:0] KIND_TILE  = 3'd0;
  localparam logic [2:0] KIND_DOOR  = 3'd1;
  localparam logic [2:0] KIND_SHIP  = 3'd2;
  localparam logic [2:0] KIND_MOVE  = 3'd3;
  localparam logic [2:0] KIND_PLACE = 3'd4;

  // register indexes
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_SPEED   = 2'd2;
  localparam logic [1:0] REG_OUTSIDE = 2'd3;

  localparam logic signed [31:0] COORD_MIN = -(32'sd1 <<< (COORD_W - 1));
  localparam logic signed [31:0] COORD_MAX = (32'sd1 <<< (COORD_W - 1)) - 32'sd1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t             x;
    coord_t             y;
    logic [EXT_W-1:0]   w;
    logic [EXT_W-1:0]   h;
  } rect_t;

  typedef struct packed {
    logic   start;
    coord_t x;
    coord_t y;
  } probe_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } probe_rsp_t;

  // clamp to the coordinate range
  function automatic coord_t sat_coord(input logic signed [31:0] v);
    coord_t r;
    if (v < COORD_MIN) begin
      r = COORD_MIN[COORD_W-1:0];
    end else if (v > COORD_MAX) begin
      r = COORD_MAX[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tmbc_ram.sv =====
// ----------------------------------------------------------------------------
// tmbc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tmbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tmbc_probe.sv =====
// ----------------------------------------------------------------------------
// tmbc_probe
// tests one candidate box position against tile rows, doors and ship hulls
// ----------------------------------------------------------------------------
module tmbc_probe #(
  parameter int MAP_COLS   = 64,
  parameter int MAP_ROWS   = 64,
  parameter int CELL_SHIFT = 13,
  parameter int DOOR_SLOTS = 16,
  parameter int SHIP_SLOTS = 8,
  localparam int RAW  = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1,
  localparam int DAW  = (DOOR_SLOTS > 1) ? $clog2(DOOR_SLOTS) : 1,
  localparam int SAW  = (SHIP_SLOTS > 1) ? $clog2(SHIP_SLOTS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tmbc_pkg::probe_req_t         req,
  output tmbc_pkg::probe_rsp_t         rsp,
  input  logic [tmbc_pkg::EXT_W-1:0]   player_width,
  input  logic [tmbc_pkg::EXT_W-1:0]   player_height,
  input  logic                         outside_is_solid,
  input  logic [DOOR_SLOTS-1:0]        door_blk,
  input  logic [SHIP_SLOTS-1:0]        ship_use,
  output logic [RAW-1:0]               tile_raddr,
  input  logic [MAP_COLS-1:0]          tile_rdata,
  output logic [DAW-1:0]               door_raddr,
  input  tmbc_pkg::rect_t              door_rdata,
  output logic [SAW-1:0]               ship_raddr,
  input  tmbc_pkg::rect_t              ship_rdata
);

  localparam int CW   = tmbc_pkg::CALC_W;
  localparam int NMAX = (MAP_ROWS > DOOR_SLOTS)
                        ? ((MAP_ROWS > SHIP_SLOTS) ? MAP_ROWS : SHIP_SLOTS)
                        : ((DOOR_SLOTS > SHIP_SLOTS) ? DOOR_SLOTS : SHIP_SLOTS);
  localparam int IW   = $clog2(NMAX + 1);

  localparam logic signed [CW-1:0] COLS_S = CW'(MAP_COLS);
  localparam logic signed [CW-1:0] ROWS_S = CW'(MAP_ROWS);
  localparam logic signed [CW-1:0] EPS_S  = CW'(tmbc_pkg::SNAP_EPS);
  localparam logic signed [CW-1:0] WALL_S = CW'(tmbc_pkg::WALL_T);

  typedef enum logic [1:0] {P_IDLE, P_SETUP, P_SCAN} pstate_t;

  pstate_t                 pstate;
  tmbc_pkg::coord_t        px;
  tmbc_pkg::coord_t        py;
  logic [RAW-1:0]          row_base;
  logic [MAP_COLS-1:0]     col_mask;
  logic [IW-1:0]           nrows;
  logic [IW-1:0]           nmax;
  logic [IW-1:0]           idx;
  logic [IW-1:0]           pidx;
  logic                    pend;

  logic signed [CW-1:0] xs, ys, ws, hs, xw, yh;
  logic signed [CW-1:0] c0, c1, r0, r1, c0c, c1c, r0c, r1c;
  logic                 empty, oob, empty2, ohit, gon;
  logic [MAP_COLS-1:0]  mask_w;
  logic [IW-1:0]        nrows_w, nmax_w;

  // box edges and grid coverage of the latched position
  always_comb begin
    xs  = CW'(px);
    ys  = CW'(py);
    ws  = {{(CW - tmbc_pkg::EXT_W){1'b0}}, player_width};
    hs  = {{(CW - tmbc_pkg::EXT_W){1'b0}}, player_height};
    xw  = xs + ws;
    yh  = ys + hs;
    c0  = xs >>> CELL_SHIFT;
    c1  = (xw - EPS_S) >>> CELL_SHIFT;
    r0  = ys >>> CELL_SHIFT;
    r1  = (yh - EPS_S) >>> CELL_SHIFT;
    empty = (c1 < c0) || (r1 < r0);
    oob   = (c0 < 0) || (r0 < 0) || (c1 >= COLS_S) || (r1 >= ROWS_S);
    c0c = (c0 < 0) ? '0 : c0;
    r0c = (r0 < 0) ? '0 : r0;
    c1c = (c1 >= COLS_S) ? COLS_S - 1 : c1;
    r1c = (r1 >= ROWS_S) ? ROWS_S - 1 : r1;
    empty2 = (c1c < c0c) || (r1c < r0c);
    ohit   = !empty && oob && outside_is_solid;
    gon    = !empty && !ohit && !empty2;
    mask_w = ({MAP_COLS{1'b1}} << c0c) & ({MAP_COLS{1'b1}} >> (COLS_S - 1 - c1c));
    nrows_w = gon ? IW'(r1c - r0c + 1) : '0;
    nmax_w  = nrows_w;
    if (IW'(DOOR_SLOTS) > nmax_w) begin
      nmax_w = IW'(DOOR_SLOTS);
    end
    if (IW'(SHIP_SLOTS) > nmax_w) begin
      nmax_w = IW'(SHIP_SLOTS);
    end
  end

  logic issue;
  logic signed [CW-1:0] dx, dy, dw, dh, sx, sy, sw, sh;
  logic d_ov, s_left, s_right, s_top, g_ok, d_ok, s_ok, hit_now;

  // read issue and evaluation of the previous read
  always_comb begin
    issue      = idx < nmax;
    tile_raddr = row_base + idx[RAW-1:0];
    door_raddr = idx[DAW-1:0];
    ship_raddr = idx[SAW-1:0];

    dx = CW'(door_rdata.x);
    dy = CW'(door_rdata.y);
    dw = {{(CW - tmbc_pkg::EXT_W){1'b0}}, door_rdata.w};
    dh = {{(CW - tmbc_pkg::EXT_W){1'b0}}, door_rdata.h};
    sx = CW'(ship_rdata.x);
    sy = CW'(ship_rdata.y);
    sw = {{(CW - tmbc_pkg::EXT_W){1'b0}}, ship_rdata.w};
    sh = {{(CW - tmbc_pkg::EXT_W){1'b0}}, ship_rdata.h};

    d_ov    = (xs < dx + dw) && (xw > dx) && (ys < dy + dh) && (yh > dy);
    s_left  = (xs < sx + WALL_S) && (xw > sx) && (ys < sy + sh) && (yh > sy);
    s_right = (xs < sx + sw) && (xw > sx + sw - WALL_S) && (ys < sy + sh) && (yh > sy);
    s_top   = (xs < sx + sw) && (xw > sx) && (ys < sy + WALL_S) && (yh > sy);

    g_ok = pidx < nrows;
    d_ok = (pidx < IW'(DOOR_SLOTS)) && door_blk[pidx[DAW-1:0]];
    s_ok = (pidx < IW'(SHIP_SLOTS)) && ship_use[pidx[SAW-1:0]];
    hit_now = pend && ((g_ok && |(tile_rdata & col_mask)) ||
                       (d_ok && d_ov) ||
                       (s_ok && (s_left || s_right || s_top)));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= P_IDLE;
      rsp    <= '0;
      pend   <= 1'b0;
      idx    <= '0;
    end else begin
      rsp <= '0;
      unique case (pstate)
        P_IDLE: begin
          if (req.start) begin
            px     <= req.x;
            py     <= req.y;
            pstate <= P_SETUP;
          end
        end
        P_SETUP: begin
          row_base <= r0c[RAW-1:0];
          col_mask <= mask_w;
          nrows    <= nrows_w;
          nmax     <= nmax_w;
          idx      <= '0;
          pend     <= 1'b0;
          if (ohit) begin
            rsp    <= '{done: 1'b1, hit: 1'b1};
            pstate <= P_IDLE;
          end else begin
            pstate <= P_SCAN;
          end
        end
        P_SCAN: begin
          pend <= issue;
          pidx <= idx;
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (hit_now) begin
            rsp    <= '{done: 1'b1, hit: 1'b1};
            pend   <= 1'b0;
            pstate <= P_IDLE;
          end else if (!issue && !pend) begin
            rsp    <= '{done: 1'b1, hit: 1'b0};
            pstate <= P_IDLE;
          end
        end
        default: pstate <= P_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tile_map_box_collision_slide.sv =====
// ----------------------------------------------------------------------------
// tile_map_box_collision_slide
// moves a player box through tiles, doors and ship hulls with axis slide
// ----------------------------------------------------------------------------
// usage
//   requests arrive on in_valid/in_ready; each gives exactly one result on
//   out_valid/out_ready carrying the player position and the two hit flags.
//   registers sit on an apb-style port; the user is to write them only
//   while the block is idle; the block itself does not enforce it. one
//   request is worked on at a time. tile writes read the row, modify it and
//   write it back. a move first multiplies speed, time and direction (S_MUL0,
//   S_MULX, S_MULY, S_MVY), then runs up to four position probes; each probe
//   sweeps tile rows, door slots and ship slots in parallel out of their
//   rams, up to max(rows covered, DOOR_SLOTS, SHIP_SLOTS) entries.
//   after reset the tile ram is cleared one row a cycle, all MAP_ROWS rows,
//   with in_ready low; register writes are taken as ever.
//   a new request is taken while the previous result still waits; if the
//   receiver stalls, the next result holds back until the output is free.
// ----------------------------------------------------------------------------
`include "tile_map_box_collision_slide_defines.svh"

module tile_map_box_collision_slide #(
  parameter int MAP_COLS   = 64,
  parameter int MAP_ROWS   = 64,
  parameter int CELL_SHIFT = 13,
  parameter int DOOR_SLOTS = 16,
  parameter int SHIP_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          kind,
  input  logic [5:0]          tile_col,
  input  logic [5:0]          tile_row,
  input  logic [3:0]          slot,
  input  logic signed [20:0]  rect_x,
  input  logic signed [20:0]  rect_y,
  input  logic [19:0]         rect_w,
  input  logic [19:0]         rect_h,
  input  logic                blocking,
  input  logic signed [15:0]  dir_x,
  input  logic signed [15:0]  dir_y,
  input  logic [15:0]         step_time,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [20:0]  pos_x,
  output logic signed [20:0]  pos_y,
  output logic                hit_x,
  output logic                hit_y
);

  localparam int RAW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int DAW = (DOOR_SLOTS > 1) ? $clog2(DOOR_SLOTS) : 1;
  localparam int SAW = (SHIP_SLOTS > 1) ? $clog2(SHIP_SLOTS) : 1;
  localparam int SD_W = tmbc_pkg::SPEED_W + tmbc_pkg::TIME_W;
  localparam int PR_W = tmbc_pkg::DIR_W + SD_W + 1;
  localparam int MV_SHIFT = 30;
  localparam logic signed [PR_W-1:0] MV_ROUND = (PR_W'(1) <<< MV_SHIFT) - PR_W'(1);
  localparam logic signed [31:0] CELL = 32'sd1 <<< CELL_SHIFT;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_TILE_RD, S_TILE_WR, S_MUL0, S_MULX, S_MULY,
    S_MVY, S_TRY, S_WAIT1, S_SNAP, S_WAIT2, S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [tmbc_pkg::EXT_W-1:0]   player_width;
  logic [tmbc_pkg::EXT_W-1:0]   player_height;
  logic [tmbc_pkg::SPEED_W-1:0] player_speed;
  logic                         outside_is_solid;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      player_width     <= 20'd6144;
      player_height    <= 20'd6144;
      player_speed     <= 24'd32768;
      outside_is_solid <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        tmbc_pkg::REG_WIDTH:   player_width     <= pwdata[tmbc_pkg::EXT_W-1:0];
        tmbc_pkg::REG_HEIGHT:  player_height    <= pwdata[tmbc_pkg::EXT_W-1:0];
        tmbc_pkg::REG_SPEED:   player_speed     <= pwdata[tmbc_pkg::SPEED_W-1:0];
        tmbc_pkg::REG_OUTSIDE: outside_is_solid <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      tmbc_pkg::REG_WIDTH:   prdata = 32'(player_width);
      tmbc_pkg::REG_HEIGHT:  prdata = 32'(player_height);
      tmbc_pkg::REG_SPEED:   prdata = 32'(player_speed);
      tmbc_pkg::REG_OUTSIDE: prdata = 32'(outside_is_solid);
      default:               prdata = '0;
    endcase
  end

  // latched request
  logic [2:0]                  k;
  logic [5:0]                  col_q;
  logic [5:0]                  row_q;
  logic [3:0]                  slot_q;
  tmbc_pkg::coord_t            rx;
  tmbc_pkg::coord_t            ry;
  logic [tmbc_pkg::EXT_W-1:0]  rw;
  logic [tmbc_pkg::EXT_W-1:0]  rh;
  logic                        blk_q;
  logic signed [15:0]          dx_q;
  logic signed [15:0]          dy_q;
  logic [15:0]                 dt_q;

  // block state
  tmbc_pkg::coord_t            player_x;
  tmbc_pkg::coord_t            player_y;
  tmbc_pkg::coord_t            mv_x;
  tmbc_pkg::coord_t            mv_y;
  tmbc_pkg::coord_t            np;
  tmbc_pkg::coord_t            old;
  tmbc_pkg::coord_t            cand;
  logic [SD_W-1:0]             sd;
  logic signed [PR_W-1:0]      prod;
  logic                        ax;
  logic                        hx;
  logic                        hy;
  logic [RAW-1:0]              clr_row;
  logic [DOOR_SLOTS-1:0]       door_blk;
  logic [SHIP_SLOTS-1:0]       ship_use;

  // memory ports
  logic                 tile_we;
  logic [RAW-1:0]       tile_waddr;
  logic [MAP_COLS-1:0]  tile_wdata;
  logic [RAW-1:0]       tile_raddr;
  logic [RAW-1:0]       probe_row;
  logic [MAP_COLS-1:0]  tile_rdata;
  logic                 door_we;
  logic                 ship_we;
  logic [DAW-1:0]       door_raddr;
  logic [SAW-1:0]       ship_raddr;
  tmbc_pkg::rect_t      door_rdata;
  tmbc_pkg::rect_t      ship_rdata;
  tmbc_pkg::rect_t      rect_in;

  tmbc_pkg::probe_req_t probe_req;
  tmbc_pkg::probe_rsp_t probe_rsp;

  logic                 tile_in_map;
  logic                 door_ok;
  logic                 ship_ok;
  logic [MAP_COLS-1:0]  col_bit;
  logic [RAW-1:0]       row_addr;

  assign in_ready    = (state == S_IDLE);
  assign tile_in_map = (int'(col_q) < MAP_COLS) && (int'(row_q) < MAP_ROWS);
  assign door_ok     = int'(slot_q) < DOOR_SLOTS;
  assign ship_ok     = int'(slot_q) < SHIP_SLOTS;
  assign col_bit     = MAP_COLS'(1) << col_q;
  assign row_addr    = RAW'(row_q);
  assign rect_in     = '{x: rx, y: ry, w: rw, h: rh};

  // tile row write: clearing pass or read-modify-write
  always_comb begin
    tile_we    = (state == S_CLEAR) || (state == S_TILE_WR);
    tile_waddr = (state == S_CLEAR) ? clr_row : row_addr;
    if (state == S_CLEAR) begin
      tile_wdata = '0;
    end else if (blk_q) begin
      tile_wdata = tile_rdata | col_bit;
    end else begin
      tile_wdata = tile_rdata & ~col_bit;
    end
    tile_raddr = (state == S_TILE_RD) ? row_addr : probe_row;
    door_we    = (state == S_EXEC) && (k == tmbc_pkg::KIND_DOOR) && door_ok;
    ship_we    = (state == S_EXEC) && (k == tmbc_pkg::KIND_SHIP) && ship_ok;
  end

  tmbc_ram #(.WIDTH(MAP_COLS), .DEPTH(MAP_ROWS)) u_tile_ram (
    .clk   (clk),
    .we    (tile_we),
    .waddr (tile_waddr),
    .wdata (tile_wdata),
    .raddr (tile_raddr),
    .rdata (tile_rdata)
  );

  tmbc_ram #(.WIDTH($bits(tmbc_pkg::rect_t)), .DEPTH(DOOR_SLOTS)) u_door_ram (
    .clk   (clk),
    .we    (door_we),
    .waddr (DAW'(slot_q)),
    .wdata (rect_in),
    .raddr (door_raddr),
    .rdata (door_rdata)
  );

  tmbc_ram #(.WIDTH($bits(tmbc_pkg::rect_t)), .DEPTH(SHIP_SLOTS)) u_ship_ram (
    .clk   (clk),
    .we    (ship_we),
    .waddr (SAW'(slot_q)),
    .wdata (rect_in),
    .raddr (ship_raddr),
    .rdata (ship_rdata)
  );

  tmbc_probe #(
    .MAP_COLS   (MAP_COLS),
    .MAP_ROWS   (MAP_ROWS),
    .CELL_SHIFT (CELL_SHIFT),
    .DOOR_SLOTS (DOOR_SLOTS),
    .SHIP_SLOTS (SHIP_SLOTS)
  ) u_probe (
    .clk              (clk),
    .rst              (rst),
    .req              (probe_req),
    .rsp              (probe_rsp),
    .player_width     (player_width),
    .player_height    (player_height),
    .outside_is_solid (outside_is_solid),
    .door_blk         (door_blk),
    .ship_use         (ship_use),
    .tile_raddr       (probe_row),
    .tile_rdata       (tile_rdata),
    .door_raddr       (door_raddr),
    .door_rdata       (door_rdata),
    .ship_raddr       (ship_raddr),
    .ship_rdata       (ship_rdata)
  );

  // move product to coordinate units, truncated toward zero
  function automatic tmbc_pkg::coord_t mv_conv(input logic signed [PR_W-1:0] p);
    logic signed [PR_W-1:0] b;
    b = p + (p[PR_W-1] ? MV_ROUND : '0);
    return tmbc_pkg::sat_coord(32'(b >>> MV_SHIFT));
  endfunction

  // truncation of a coordinate toward zero to a cell edge
  function automatic logic signed [31:0] cell_trunc(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = (v < 0) ? v + CELL - 32'sd1 : v;
    return t & ~(CELL - 32'sd1);
  endfunction

  tmbc_pkg::coord_t   cur;
  tmbc_pkg::coord_t   mv;
  tmbc_pkg::coord_t   np_w;
  tmbc_pkg::coord_t   cand_w;
  tmbc_pkg::coord_t   probe_pos;
  logic signed [31:0] ext;

  // axis step, snap candidate and probe request
  always_comb begin
    cur  = ax ? player_y : player_x;
    mv   = ax ? mv_y : mv_x;
    ext  = 32'(ax ? player_height : player_width);
    np_w = tmbc_pkg::sat_coord(32'(cur) + 32'(mv));
    if (mv > 0) begin
      cand_w = tmbc_pkg::sat_coord(cell_trunc(32'(np) + ext) - ext
                                   - 32'(tmbc_pkg::SNAP_EPS));
    end else begin
      cand_w = tmbc_pkg::sat_coord(cell_trunc(32'(np)) + CELL
                                   + 32'(tmbc_pkg::SNAP_EPS));
    end
    probe_pos       = (state == S_SNAP) ? cand : np_w;
    probe_req.start = (state == S_TRY) || (state == S_SNAP);
    probe_req.x     = ax ? player_x : probe_pos;
    probe_req.y     = ax ? probe_pos : player_y;
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      out_valid <= 1'b0;
      player_x  <= '0;
      player_y  <= '0;
      door_blk  <= '0;
      ship_use  <= '0;
      ax        <= 1'b0;
      hx        <= 1'b0;
      hy        <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == RAW'(MAP_ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            k      <= kind;
            col_q  <= tile_col;
            row_q  <= tile_row;
            slot_q <= slot;
            rx     <= rect_x;
            ry     <= rect_y;
            rw     <= rect_w;
            rh     <= rect_h;
            blk_q  <= blocking;
            dx_q   <= dir_x;
            dy_q   <= dir_y;
            dt_q   <= step_time;
            hx     <= 1'b0;
            hy     <= 1'b0;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (k)
            tmbc_pkg::KIND_TILE: state <= tile_in_map ? S_TILE_RD : S_FIN;
            tmbc_pkg::KIND_DOOR: begin
              if (door_ok) begin
                door_blk[DAW'(slot_q)] <= blk_q;
              end
              state <= S_FIN;
            end
            tmbc_pkg::KIND_SHIP: begin
              if (ship_ok) begin
                ship_use[SAW'(slot_q)] <= blk_q;
              end
              state <= S_FIN;
            end
            tmbc_pkg::KIND_MOVE: state <= S_MUL0;
            tmbc_pkg::KIND_PLACE: begin
              player_x <= rx;
              player_y <= ry;
              state    <= S_FIN;
            end
            default: state <= S_FIN;
          endcase
        end
        S_TILE_RD: state <= S_TILE_WR;
        S_TILE_WR: state <= S_FIN;
        S_MUL0: begin
          sd    <= SD_W'(player_speed) * SD_W'(dt_q);
          state <= S_MULX;
        end
        S_MULX: begin
          prod  <= PR_W'(dx_q) * PR_W'($signed({1'b0, sd}));
          state <= S_MULY;
        end
        S_MULY: begin
          mv_x  <= mv_conv(prod);
          prod  <= PR_W'(dy_q) * PR_W'($signed({1'b0, sd}));
          state <= S_MVY;
        end
        S_MVY: begin
          mv_y  <= mv_conv(prod);
          ax    <= 1'b0;
          state <= S_TRY;
        end
        S_TRY: begin
          np    <= np_w;
          old   <= cur;
          state <= S_WAIT1;
        end
        S_WAIT1: begin
          if (probe_rsp.done) begin
            if (!probe_rsp.hit) begin
              if (ax) player_y <= np;
              else    player_x <= np;
              ax    <= 1'b1;
              state <= ax ? S_FIN : S_TRY;
            end else begin
              if (ax) hy <= 1'b1;
              else    hx <= 1'b1;
              if (mv == '0) begin
                ax    <= 1'b1;
                state <= ax ? S_FIN : S_TRY;
              end else begin
                cand  <= cand_w;
                state <= S_SNAP;
              end
            end
          end
        end
        S_SNAP: state <= S_WAIT2;
        S_WAIT2: begin
          if (probe_rsp.done) begin
            if (ax) player_y <= probe_rsp.hit ? old : cand;
            else    player_x <= probe_rsp.hit ? old : cand;
            ax    <= 1'b1;
            state <= ax ? S_FIN : S_TRY;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            pos_x     <= player_x;
            pos_y     <= player_y;
            hit_x     <= hx;
            hit_y     <= hy;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `TMBC_ASSERT_SAME(a_probe_done_waited, clk, rst, probe_rsp.done, state == S_WAIT1 || state == S_WAIT2)
  `TMBC_ASSERT_NEXT(a_accept_to_exec, clk, rst, in_valid && in_ready, state == S_EXEC)
  `TMBC_ASSERT_NEXT(a_result_held, clk, rst, state == S_FIN && out_valid && !out_ready, state == S_FIN && out_valid)
  `TMBC_ASSERT_NEXT(a_probe_min_latency, clk, rst, probe_req.start, !probe_rsp.done)

endmodule

// ===== tb/tile_map_box_collision_slide_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile map box mover checker
// watches the register port and both channels, keeps its own copy of tiles,
// doors, ships and player, predicts each result and compares in order
// ----------------------------------------------------------------------------
module tile_map_box_collision_slide_checker
  import tmbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [5:0]         tile_col,
  input  logic [5:0]         tile_row,
  input  logic [3:0]         slot,
  input  logic signed [20:0] rect_x,
  input  logic signed [20:0] rect_y,
  input  logic [19:0]        rect_w,
  input  logic [19:0]        rect_h,
  input  logic               blocking,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic [15:0]        step_time,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [20:0] pos_x,
  input  logic signed [20:0] pos_y,
  input  logic               hit_x,
  input  logic               hit_y,
  output int                 fail_count,
  output int                 pending
);

  localparam int      N_COLS  = 64;
  localparam int      N_ROWS  = 64;
  localparam longint  CELL    = 8192;
  localparam int      N_DOORS = 16;
  localparam int      N_SHIPS = 8;
  localparam longint  LO      = -1048576;
  localparam longint  HI      = 1048575;

  typedef struct {
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic               hx;
    logic               hy;
  } position_t;

  // model state
  bit     solid_tile [0:N_COLS*N_ROWS-1];
  longint door_x [N_DOORS], door_y [N_DOORS], door_w [N_DOORS], door_h [N_DOORS];
  bit     door_blk [N_DOORS];
  longint ship_x [N_SHIPS], ship_y [N_SHIPS], ship_w [N_SHIPS], ship_h [N_SHIPS];
  bit     ship_used [N_SHIPS];
  longint px, py, box_w, box_h, speed;
  bit     out_solid;

  position_t expected_pos [$];

  assign pending = expected_pos.size();

  function automatic longint clamp_coord(longint v);
    return v < LO ? LO : (v > HI ? HI : v);
  endfunction

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if (a % d != 0 && a < 0) q--;
    return q;
  endfunction

  // tile coverage of a box, far edge pulled in by the epsilon
  function automatic bit tiles_hit(longint x, longint y, longint w, longint h);
    longint c0, c1, r0, r1;
    bit     found;
    found = 0;
    c0 = fdiv(x, CELL);
    c1 = fdiv(x + w - SNAP_EPS, CELL);
    r0 = fdiv(y, CELL);
    r1 = fdiv(y + h - SNAP_EPS, CELL);
    if (c1 < c0 || r1 < r0) return 0;
    if (c0 < 0 || r0 < 0 || c1 >= N_COLS || r1 >= N_ROWS) begin
      if (out_solid) return 1;
      if (c0 < 0) c0 = 0;
      if (r0 < 0) r0 = 0;
      if (c1 >= N_COLS) c1 = N_COLS - 1;
      if (r1 >= N_ROWS) r1 = N_ROWS - 1;
      if (c1 < c0 || r1 < r0) return 0;
    end
    for (longint r = r0; r <= r1; r++)
      for (longint c = c0; c <= c1; c++)
        if (solid_tile[r*N_COLS + c]) found = 1;
    return found;
  endfunction

  function automatic bit boxes_meet(longint x, longint y, longint w, longint h,
                                    longint bx, longint by, longint bw, longint bh);
    return x < bx + bw && x + w > bx && y < by + bh && y + h > by;
  endfunction

  function automatic bit blocked(longint x, longint y);
    longint w, h;
    w = box_w;
    h = box_h;
    if (tiles_hit(x, y, w, h)) return 1;
    for (int i = 0; i < N_DOORS; i++)
      if (door_blk[i] && boxes_meet(x, y, w, h, door_x[i], door_y[i], door_w[i], door_h[i]))
        return 1;
    // ships: left wall, right wall, top wall; bottom is open
    for (int i = 0; i < N_SHIPS; i++) begin
      if (!ship_used[i]) continue;
      if (x + w < ship_x[i] - WALL_T || x > ship_x[i] + ship_w[i] + WALL_T ||
          y + h < ship_y[i] - WALL_T || y > ship_y[i] + ship_h[i] + WALL_T)
        continue;
      if (boxes_meet(x, y, w, h, ship_x[i], ship_y[i], WALL_T, ship_h[i])) return 1;
      if (boxes_meet(x, y, w, h, ship_x[i] + ship_w[i] - WALL_T, ship_y[i],
                     WALL_T, ship_h[i])) return 1;
      if (boxes_meet(x, y, w, h, ship_x[i], ship_y[i], ship_w[i], WALL_T)) return 1;
    end
    return 0;
  endfunction

  // full step, then snap to the cell edge, then stay put
  task automatic slide_axis(inout longint p, input longint ext, input longint mv,
                            input bit on_x, output bit hit);
    longint np, cand;
    np = clamp_coord(p + mv);
    cand = p;
    if (!(on_x ? blocked(np, py) : blocked(px, np))) begin
      p = np;
      hit = 0;
      return;
    end
    if (mv > 0)
      cand = clamp_coord(((np + ext) / CELL) * CELL - ext - SNAP_EPS);
    else if (mv < 0)
      cand = clamp_coord((np / CELL + 1) * CELL + SNAP_EPS);
    if (on_x ? blocked(cand, py) : blocked(px, cand)) cand = p;
    p = cand;
    hit = 1;
  endtask

  task automatic apply_request();
    position_t e;
    longint    mx, my, nx, ny;
    bit        hx, hy;
    hx = 0;
    hy = 0;
    case (kind)
      KIND_TILE: solid_tile[int'(tile_row)*N_COLS + int'(tile_col)] = blocking;
      KIND_DOOR: begin
        door_x[slot] = rect_x;
        door_y[slot] = rect_y;
        door_w[slot] = rect_w;
        door_h[slot] = rect_h;
        door_blk[slot] = blocking;
      end
      KIND_SHIP: if (slot < N_SHIPS) begin
        ship_x[slot] = rect_x;
        ship_y[slot] = rect_y;
        ship_w[slot] = rect_w;
        ship_h[slot] = rect_h;
        ship_used[slot] = blocking;
      end
      KIND_MOVE: begin
        mx = clamp_coord((longint'(dir_x) * speed * longint'(step_time)) / 1073741824);
        my = clamp_coord((longint'(dir_y) * speed * longint'(step_time)) / 1073741824);
        nx = px;
        slide_axis(nx, box_w, mx, 1, hx);
        px = nx;
        ny = py;
        slide_axis(ny, box_h, my, 0, hy);
        py = ny;
      end
      KIND_PLACE: begin
        px = rect_x;
        py = rect_y;
      end
      default: ;
    endcase
    e.x = px[20:0];
    e.y = py[20:0];
    e.hx = hx;
    e.hy = hy;
    expected_pos.push_back(e);
  endtask

  always @(posedge clk) begin
    position_t e;
    if (rst) begin
      foreach (solid_tile[i]) solid_tile[i] = 0;
      for (int i = 0; i < N_DOORS; i++) begin
        door_x[i] = 0; door_y[i] = 0; door_w[i] = 0; door_h[i] = 0; door_blk[i] = 0;
      end
      for (int i = 0; i < N_SHIPS; i++) begin
        ship_x[i] = 0; ship_y[i] = 0; ship_w[i] = 0; ship_h[i] = 0; ship_used[i] = 0;
      end
      px = 0;
      py = 0;
      box_w = 6144;
      box_h = 6144;
      speed = 32768;
      out_solid = 1;
      expected_pos.delete();
      fail_count = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WIDTH:   box_w = pwdata[19:0];
          REG_HEIGHT:  box_h = pwdata[19:0];
          REG_SPEED:   speed = pwdata[23:0];
          REG_OUTSIDE: out_solid = pwdata[0];
          default: ;
        endcase
      end
      // result compare against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_pos.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result x=%0d y=%0d", pos_x, pos_y);
        end else begin
          e = expected_pos.pop_front();
          if (pos_x !== e.x || pos_y !== e.y || hit_x !== e.hx || hit_y !== e.hy) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected x=%0d y=%0d hx=%0b hy=%0b, got x=%0d y=%0d hx=%0b hy=%0b",
                       e.x, e.y, e.hx, e.hy, pos_x, pos_y, hit_x, hit_y);
          end
        end
      end
      if (in_valid && in_ready) apply_request();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile map box mover testbench
// directed and random requests over several register settings, random idling
// on both channels, a long receiver hold-off; checking in the checker module
// ----------------------------------------------------------------------------
module tb_top;
  import tmbc_pkg::*;

  localparam logic [2:0] KIND_BAD_FIRST = 3'd5;
  localparam logic [2:0] KIND_BAD_LAST  = 3'd7;
  localparam int         DRAIN_CYCLES   = 600;
  localparam int         HOLD_CYCLES    = 500;
  localparam int         WATCH_LIMIT    = 20000;
  localparam int         RANDOM_PER_SET = 245;

  typedef struct packed {
    logic [2:0]         kind;
    logic [5:0]         col;
    logic [5:0]         row;
    logic [3:0]         slot;
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic [19:0]        w;
    logic [19:0]        h;
    logic               blk;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [15:0]        dt;
  } mover_req_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [2:0]  kind = '0;
  logic [5:0]  tile_col = '0, tile_row = '0;
  logic [3:0]  slot = '0;
  logic signed [20:0] rect_x = '0, rect_y = '0, pos_x, pos_y;
  logic [19:0] rect_w = '0, rect_h = '0;
  logic blocking = 0, hit_x, hit_y;
  logic signed [15:0] dir_x = '0, dir_y = '0;
  logic [15:0] step_time = '0;

  int fail_count, pending;
  int send_idle, recv_idle;
  bit hold_req;
  int hold_left;
  int quiet_cycles;

  always #10 clk = ~clk;

  tile_map_box_collision_slide dut (.*);

  tile_map_box_collision_slide_checker checker_i (.*);

  // receiver: random stalls, plus one long hold-off on demand
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles with nothing accepted anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
  endtask

  task automatic send_request(input mover_req_t r);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle) @(negedge clk);
    end
    kind <= r.kind;
    tile_col <= r.col;
    tile_row <= r.row;
    slot <= r.slot;
    rect_x <= r.x;
    rect_y <= r.y;
    rect_w <= r.w;
    rect_h <= r.h;
    blocking <= r.blk;
    dir_x <= r.dx;
    dir_y <= r.dy;
    step_time <= r.dt;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // sender pause until the block has gone quiet
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic mover_req_t build(input logic [2:0] k, input int ax, input int ay,
                                       input int aw, input int ah, input bit b);
    mover_req_t r;
    r = '0;
    r.kind = k;
    r.x = ax;
    r.y = ay;
    r.w = aw;
    r.h = ah;
    r.blk = b;
    return r;
  endfunction

  // mostly requests in a small playground near the map origin, some raw noise
  function automatic mover_req_t random_request();
    mover_req_t r;
    int pick;
    r.kind = 0;
    r.col = $urandom;
    r.row = $urandom;
    r.slot = $urandom;
    r.x = $urandom;
    r.y = $urandom;
    r.w = $urandom;
    r.h = $urandom;
    r.blk = $urandom;
    r.dx = $urandom_range(0, 32768) - 16384;
    r.dy = $urandom_range(0, 32768) - 16384;
    r.dt = $urandom;
    pick = $urandom_range(99);
    if (pick < 25) r.kind = KIND_TILE;
    else if (pick < 33) r.kind = KIND_DOOR;
    else if (pick < 41) r.kind = KIND_SHIP;
    else if (pick < 83) r.kind = KIND_MOVE;
    else if (pick < 93) r.kind = KIND_PLACE;
    else r.kind = $urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST);
    if ($urandom_range(99) < 10) return r;
    case (r.kind)
      KIND_TILE: begin
        r.col = $urandom_range(0, 11);
        r.row = $urandom_range(0, 11);
        r.blk = ($urandom_range(99) < 40);
      end
      KIND_DOOR: begin
        r.x = $urandom_range(0, 100000);
        r.y = $urandom_range(0, 100000);
        r.w = $urandom_range(0, 12000);
        r.h = $urandom_range(0, 12000);
      end
      KIND_SHIP: begin
        r.x = $urandom_range(0, 100000);
        r.y = $urandom_range(0, 100000);
        r.w = $urandom_range(2048, 30000);
        r.h = $urandom_range(2048, 30000);
      end
      KIND_MOVE: r.dt = $urandom_range(0, 30000);
      KIND_PLACE: begin
        r.x = $urandom_range(0, 90000);
        r.y = $urandom_range(0, 90000);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic directed_requests();
    mover_req_t r;
    // tile extremes and a wall to slide into
    r = build(KIND_TILE, 0, 0, 0, 0, 1); r.col = 63; r.row = 63; send_request(r);
    r = build(KIND_TILE, 0, 0, 0, 0, 1); r.col = 2; r.row = 1; send_request(r);
    r = build(KIND_TILE, 0, 0, 0, 0, 1); r.col = 1; r.row = 3; send_request(r);
    r = build(KIND_TILE, 0, 0, 0, 0, 0); r.col = 63; r.row = 63; send_request(r);
    // snap right into a tile, then a free step down
    send_request(build(KIND_PLACE, 9000, 9000, 0, 0, 0));
    r = build(KIND_MOVE, 0, 0, 0, 0, 0); r.dx = 16384; r.dy = 16384; r.dt = 16384;
    send_request(r);
    // leftward into the map edge with outside solid
    r = build(KIND_MOVE, 0, 0, 0, 0, 0); r.dx = -16384; r.dy = -16384; r.dt = 65535;
    send_request(r);
    // zero step
    r = build(KIND_MOVE, 0, 0, 0, 0, 0); r.dx = 0; r.dy = 0; r.dt = 65535; send_request(r);
    // coordinate extremes
    send_request(build(KIND_PLACE, 1048575, -1048576, 0, 0, 0));
    r = build(KIND_MOVE, 0, 0, 0, 0, 0); r.dx = 16384; r.dy = -16384; r.dt = 65535;
    send_request(r);
    send_request(build(KIND_PLACE, -1048576, 1048575, 0, 0, 0));
    // doors and ships, including out of range ship slots
    r = build(KIND_DOOR, 30000, 8000, 4000, 20000, 1); r.slot = 15; send_request(r);
    r = build(KIND_DOOR, -1048576, -1048576, 1048575, 1048575, 0); r.slot = 0;
    send_request(r);
    r = build(KIND_SHIP, 50000, 40000, 20000, 20000, 1); r.slot = 7; send_request(r);
    r = build(KIND_SHIP, 0, 0, 100000, 100000, 1); r.slot = 8; send_request(r);
    r = build(KIND_SHIP, 0, 0, 100000, 100000, 1); r.slot = 15; send_request(r);
    send_request(build(KIND_PLACE, 24000, 9000, 0, 0, 0));
    r = build(KIND_MOVE, 0, 0, 0, 0, 0); r.dx = 16384; r.dt = 20000; send_request(r);
    send_request(build(KIND_PLACE, 55000, 70000, 0, 0, 0));
    r = build(KIND_MOVE, 0, 0, 0, 0, 0); r.dy = -16384; r.dt = 30000; send_request(r);
    // unknown kinds
    send_request(build(KIND_BAD_FIRST, 1, 1, 1, 1, 1));
    send_request(build(KIND_BAD_LAST, 1, 1, 1, 1, 1));
  endtask

  initial begin
    send_idle = 0;
    recv_idle = 0;
    hold_req = 0;
    hold_left = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    for (int set = 0; set < 4; set++) begin
      case (set)
        0: begin
          reg_write(REG_WIDTH, 6144);
          reg_write(REG_HEIGHT, 6144);
          reg_write(REG_SPEED, 32768);
          reg_write(REG_OUTSIDE, 1);
          send_idle = 22;
          recv_idle = 64;
        end
        1: begin
          reg_write(REG_WIDTH, 0);
          reg_write(REG_HEIGHT, 0);
          reg_write(REG_SPEED, 24'hFFFFFF);
          reg_write(REG_OUTSIDE, 0);
          send_idle = 64;
          recv_idle = 22;
        end
        2: begin
          reg_write(REG_WIDTH, 20'hFFFFF);
          reg_write(REG_HEIGHT, 1);
          reg_write(REG_SPEED, 0);
          reg_write(REG_OUTSIDE, 0);
          send_idle = 0;
          recv_idle = 0;
        end
        default: begin
          reg_write(REG_WIDTH, 3000);
          reg_write(REG_HEIGHT, 9000);
          reg_write(REG_SPEED, 65536);
          reg_write(REG_OUTSIDE, 1);
        end
      endcase
      if (set == 0) directed_requests();
      for (int n = 0; n < RANDOM_PER_SET; n++) begin
        if (set == 3 && n == 20) hold_req = 1;
        send_request(random_request());
      end
      drain();
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
